// ===== rtl/lsqtm_pkg.sv =====
package lsqtm_pkg;

  localparam int LOAD_DEPTH  = 32;
  localparam int STORE_DEPTH = 32;
  localparam int LOAD_IDX_W  = $clog2(LOAD_DEPTH);
  localparam int STORE_IDX_W = $clog2(STORE_DEPTH);

  localparam int TIME_W = 48;
  localparam int ADDR_W = 64;
  localparam int LAT_W  = 16;
  localparam int CYC_W  = 16;
  localparam int OP_W   = 3;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [OP_W-1:0] OP_LOAD   = 3'd0;
  localparam logic [OP_W-1:0] OP_STORE  = 3'd1;
  localparam logic [OP_W-1:0] OP_LFENCE = 3'd2;
  localparam logic [OP_W-1:0] OP_SFENCE = 3'd3;
  localparam logic [OP_W-1:0] OP_FENCE  = 3'd4;

  localparam logic [CFG_IDX_W-1:0] CFG_SPEC  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MRFO  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CYCLE = 2'd2;

  localparam int STEP_W = 4;
  localparam logic [STEP_W-1:0] STEP_IDLE    = 4'd0;
  localparam logic [STEP_W-1:0] STEP_BASE    = 4'd1;
  localparam logic [STEP_W-1:0] STEP_ISSUE   = 4'd2;
  localparam logic [STEP_W-1:0] STEP_MATCH   = 4'd3;
  localparam logic [STEP_W-1:0] STEP_ACT2    = 4'd4;
  localparam logic [STEP_W-1:0] STEP_SUM     = 4'd5;
  localparam logic [STEP_W-1:0] STEP_DEALLOC = 4'd6;
  localparam logic [STEP_W-1:0] STEP_STADD   = 4'd7;
  localparam logic [STEP_W-1:0] STEP_COMMIT  = 4'd8;
  localparam logic [STEP_W-1:0] STEP_FENCE   = 4'd9;

  typedef logic [TIME_W-1:0] time_t;

  typedef struct packed {
    logic              latch;
    logic [STEP_W-1:0] step;
  } cmd_t;

  function automatic time_t tadd(input time_t a, input time_t b);
    logic [TIME_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[TIME_W] ? {TIME_W{1'b1}} : s[TIME_W-1:0];
  endfunction

  function automatic time_t tmax(input time_t a, input time_t b);
    return (a > b) ? a : b;
  endfunction

endpackage

// ===== rtl/load_store_queue_timing_model_unit.sv =====
// A load steps through BASE, ISSUE, MATCH, ACT2, SUM, DEALLOC and COMMIT; a store adds
// STADD before COMMIT, and a fence or an unused opcode takes the FENCE step. done is
// registered from COMMIT or FENCE. The next request is taken in the strobe cycle; while
// busy the step sequencer accepts no new request, so one request finishes before the next.
// The result receiver cannot stall; a result is shown for one cycle with done.
// Synchronous reset empties both queues, clears fences and restores register defaults.
module load_store_queue_timing_model_unit (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  output logic                               busy,
  input  logic [lsqtm_pkg::OP_W-1:0]         opcode,
  input  logic [lsqtm_pkg::TIME_W-1:0]       sched_stamp,
  input  logic [lsqtm_pkg::TIME_W-1:0]       ready_time,
  input  logic [lsqtm_pkg::ADDR_W-1:0]       address,
  input  logic [lsqtm_pkg::LAT_W-1:0]        latency,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [lsqtm_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [lsqtm_pkg::CFG_DATA_W-1:0]   cfg_data,
  output logic                               done,
  output logic [lsqtm_pkg::TIME_W-1:0]       alloc_stamp,
  output logic [lsqtm_pkg::TIME_W-1:0]       comp_stamp,
  output logic [lsqtm_pkg::TIME_W-1:0]       dealloc_stamp,
  output logic                               forwarded
);
  import lsqtm_pkg::*;

  cmd_t cmd;

  assign cfg_ready = 1'b1;

  lsqtm_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .opcode (opcode),
    .busy   (busy),
    .done   (done),
    .cmd    (cmd)
  );

  lsqtm_dpath u_dpath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .opcode        (opcode),
    .sched_stamp   (sched_stamp),
    .ready_time    (ready_time),
    .address       (address),
    .latency       (latency),
    .cfg_valid     (cfg_valid),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .alloc_stamp   (alloc_stamp),
    .comp_stamp    (comp_stamp),
    .dealloc_stamp (dealloc_stamp),
    .forwarded     (forwarded)
  );

endmodule

// ===== rtl/lsqtm_ctrl.sv =====
module lsqtm_ctrl (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [lsqtm_pkg::OP_W-1:0]   opcode,
  output logic                         busy,
  output logic                         done,
  output lsqtm_pkg::cmd_t              cmd
);
  import lsqtm_pkg::*;

  logic [STEP_W-1:0] state;
  logic [STEP_W-1:0] state_next;
  logic              is_store;
  logic              accept;

  assign busy   = (state != STEP_IDLE);
  assign accept = start && !busy;

  assign cmd.latch = accept;
  assign cmd.step  = state;

  always_comb begin
    state_next = state;
    case (state)
      STEP_IDLE: begin
        if (accept) begin
          if (opcode inside {OP_LOAD, OP_STORE}) begin
            state_next = STEP_BASE;
          end else begin
            state_next = STEP_FENCE;
          end
        end
      end
      STEP_BASE:    state_next = STEP_ISSUE;
      STEP_ISSUE:   state_next = STEP_MATCH;
      STEP_MATCH:   state_next = STEP_ACT2;
      STEP_ACT2:    state_next = STEP_SUM;
      STEP_SUM:     state_next = STEP_DEALLOC;
      STEP_DEALLOC: state_next = is_store ? STEP_STADD : STEP_COMMIT;
      STEP_STADD:   state_next = STEP_COMMIT;
      STEP_COMMIT:  state_next = STEP_IDLE;
      STEP_FENCE:   state_next = STEP_IDLE;
      default:      state_next = STEP_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= STEP_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= (state == STEP_COMMIT) || (state == STEP_FENCE);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      is_store <= (opcode == OP_STORE);
    end
  end

endmodule

// ===== rtl/lsqtm_dpath.sv =====
module lsqtm_dpath (
  input  logic                               clk,
  input  logic                               rst,
  input  lsqtm_pkg::cmd_t                    cmd,
  input  logic [lsqtm_pkg::OP_W-1:0]         opcode,
  input  logic [lsqtm_pkg::TIME_W-1:0]       sched_stamp,
  input  logic [lsqtm_pkg::TIME_W-1:0]       ready_time,
  input  logic [lsqtm_pkg::ADDR_W-1:0]       address,
  input  logic [lsqtm_pkg::LAT_W-1:0]        latency,
  input  logic                               cfg_valid,
  input  logic [lsqtm_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [lsqtm_pkg::CFG_DATA_W-1:0]   cfg_data,
  output logic [lsqtm_pkg::TIME_W-1:0]       alloc_stamp,
  output logic [lsqtm_pkg::TIME_W-1:0]       comp_stamp,
  output logic [lsqtm_pkg::TIME_W-1:0]       dealloc_stamp,
  output logic                               forwarded
);
  import lsqtm_pkg::*;

  logic                   spec;
  logic                   mrfo;
  logic [CYC_W-1:0]       cyc;

  time_t                  load_ft [LOAD_DEPTH];
  logic [LOAD_DEPTH-1:0]  load_valid;
  logic [LOAD_IDX_W-1:0]  lslot;
  time_t                  load_fence;
  time_t                  last_load;

  time_t                  store_ft [STORE_DEPTH];
  logic [ADDR_W-1:0]      store_addr [STORE_DEPTH];
  logic [STORE_DEPTH-1:0] store_valid;
  logic [STORE_IDX_W-1:0] sslot;
  time_t                  store_fence;
  time_t                  last_store;

  logic [OP_W-1:0]        op;
  time_t                  sched;
  time_t                  ready;
  logic [ADDR_W-1:0]      addr;
  logic [LAT_W-1:0]       lat;
  time_t                  alloc;
  time_t                  issue;
  time_t                  actual;
  time_t                  prior;
  time_t                  sum;
  time_t                  lastcl;
  time_t                  fwdc;
  time_t                  dealloc;
  time_t                  comp;
  logic                   fwd;
  logic [STORE_DEPTH-1:0] hit;

  logic                   is_store;
  time_t                  cl;
  time_t                  lat_ext;
  time_t                  lq;
  time_t                  sq;
  time_t                  fence_max;

  assign is_store  = (op == OP_STORE);
  assign cl        = {{(TIME_W-CYC_W){1'b0}}, cyc};
  assign lat_ext   = {{(TIME_W-LAT_W){1'b0}}, lat};
  assign lq        = load_valid[lslot] ? load_ft[lslot] : '0;
  assign sq        = store_valid[sslot] ? store_ft[sslot] : '0;
  assign fence_max = tmax(last_load, last_store);

  always_ff @(posedge clk) begin
    if (rst) begin
      spec        <= 1'b1;
      mrfo        <= 1'b1;
      cyc         <= CYC_W'(1);
      load_valid  <= '0;
      lslot       <= '0;
      load_fence  <= '0;
      last_load   <= '0;
      store_valid <= '0;
      sslot       <= '0;
      store_fence <= '0;
      last_store  <= '0;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          CFG_SPEC:  spec <= cfg_data[0];
          CFG_MRFO:  mrfo <= cfg_data[0];
          CFG_CYCLE: cyc  <= cfg_data[CYC_W-1:0];
          default:   ;
        endcase
      end
      if (cmd.step == STEP_COMMIT) begin
        if (is_store) begin
          store_valid[sslot] <= 1'b1;
          last_store         <= dealloc;
          sslot <= (sslot == STORE_IDX_W'(STORE_DEPTH-1)) ? '0 : sslot + 1'b1;
        end else begin
          load_valid[lslot] <= 1'b1;
          last_load         <= dealloc;
          lslot <= (lslot == LOAD_IDX_W'(LOAD_DEPTH-1)) ? '0 : lslot + 1'b1;
        end
      end
      if (cmd.step == STEP_FENCE) begin
        case (op)
          OP_LFENCE: load_fence <= last_load;
          OP_SFENCE: store_fence <= last_store;
          OP_FENCE: begin
            load_fence  <= fence_max;
            store_fence <= fence_max;
          end
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      op    <= opcode;
      sched <= sched_stamp;
      ready <= ready_time;
      addr  <= address;
      lat   <= latency;
    end
    case (cmd.step)
      STEP_BASE: begin
        alloc <= tmax(tadd(is_store ? sq : lq, cl), sched);
        prior <= fence_max;
      end
      STEP_ISSUE: begin
        issue <= tmax(alloc, ready);
      end
      STEP_MATCH: begin
        for (int i = 0; i < STORE_DEPTH; i++) begin
          hit[i] <= store_valid[i] && (store_addr[i] == addr) && (store_ft[i] >= issue);
        end
        actual <= tmax(issue, is_store ? store_fence : load_fence);
      end
      STEP_ACT2: begin
        fwd <= !is_store && (|hit);
        if (is_store) begin
          if (!mrfo) begin
            actual <= tmax(actual, prior);
          end
        end else if (!spec) begin
          actual <= tmax(actual, last_load);
        end
      end
      STEP_SUM: begin
        sum    <= tadd(actual, fwd ? cl : lat_ext);
        lastcl <= tadd(last_load, cl);
        fwdc   <= tadd(issue, cl);
      end
      STEP_DEALLOC: begin
        if (is_store) begin
          dealloc <= mrfo ? tmax(sum, prior) : sum;
          comp    <= actual;
        end else begin
          dealloc <= spec ? tmax(sum, lastcl) : sum;
          comp    <= fwd ? fwdc : sum;
        end
      end
      STEP_STADD: begin
        if (mrfo) begin
          dealloc <= tadd(dealloc, cl);
        end
      end
      STEP_COMMIT: begin
        alloc_stamp   <= alloc;
        comp_stamp    <= comp;
        dealloc_stamp <= dealloc;
        forwarded     <= fwd;
        if (is_store) begin
          store_ft[sslot]   <= dealloc;
          store_addr[sslot] <= addr;
        end else begin
          load_ft[lslot] <= dealloc;
        end
      end
      STEP_FENCE: begin
        comp_stamp    <= '0;
        dealloc_stamp <= '0;
        forwarded     <= 1'b0;
        case (op)
          OP_LFENCE: alloc_stamp <= last_load;
          OP_SFENCE: alloc_stamp <= last_store;
          OP_FENCE:  alloc_stamp <= fence_max;
          default:   alloc_stamp <= '0;
        endcase
      end
      default: ;
    endcase
  end

endmodule
